@@ hw/rtl/eiuc_pkg.sv @@
// Shared types, constants and the ones' complement adder of the checksum checker.
package eiuc_pkg;

    localparam int OFFSET_BITS = 17;
    localparam int LEN_BITS    = 18;
    localparam int CMP_BITS    = (OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS;

    localparam int IP_START     = 14;
    localparam int IP_CSUM_HI   = 24;
    localparam int IP_CSUM_LO   = 25;
    localparam int PSEUDO_START = 26;
    localparam int UDP_START    = 34;
    localparam int UDP_CSUM_HI  = 40;
    localparam int UDP_CSUM_LO  = 41;
    localparam int UDP_HDR_LEN  = 8;
    localparam int UDP_PROTO    = 17;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [1:0] MODE_IP   = 2'd0;
    localparam logic [1:0] MODE_UDP  = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [1:0]  check_mode;
        logic [15:0] expected_csum;
        logic [15:0] expected_ip_csum;
        logic        combined_given;
        logic        length_given;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic        checks_pass;
        logic [15:0] computed_udp_csum;
        logic [15:0] computed_ip_csum;
        logic        frame_too_short;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] exp_csum;
        logic [15:0] exp_ip;
        logic        comb;
        logic        len_ok;
        logic [15:0] plen;
    } t_frame_cfg;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] n_bytes;
        logic [15:0]            ip_sum;
        logic [15:0]            udp_sum;
        logic [3:0]             hdr_words;
        t_frame_cfg             cfg;
    } t_frame_sum;

    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

@@ hw/rtl/eth_ipv4_udp_checksum_checker_top.sv @@
// Top level of the IPv4 header and UDP checksum checker.
//
//  Channel  | Direction | Handshake                     | Payload
//  ---------+-----------+-------------------------------+-----------------------------
//  frame in | input     | i_push / o_full, push & !full | i_in  (t_in_item, one byte)
//  result   | output    | o_empty / i_pop, pop & !empty | o_out (t_out_item, per frame)
//
// One byte is taken in every cycle while o_full is low; each byte costs at most one end-around-carry add per sum.
// A frame's summary is written into the queue at the edge that takes its last byte; the final
// add and compare then feed the result register, loaded once that register is empty or popped.
// Reset is synchronous and active low and clears the offset, sums, queue and result valid.
// A stalled result fills the two-entry summary queue; o_full then holds the byte stream.
module eth_ipv4_udp_checksum_checker_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  eiuc_pkg::t_in_item  i_in,
    output logic                o_empty,
    input  logic                i_pop,
    output eiuc_pkg::t_out_item o_out
);
    import eiuc_pkg::*;

    logic       accept;
    logic       q_push;
    t_frame_sum q_wdata;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;
    t_frame_sum q_rdata;

    assign o_full = q_full;
    assign accept = i_push && !q_full;

    eiuc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .o_q_push (q_push),
        .o_q_data (q_wdata)
    );

    eiuc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rdata)
    );

    eiuc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_rdata),
        .o_q_pop   (q_pop),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_out     (o_out)
    );

endmodule

@@ hw/rtl/eiuc_front.sv @@
// Front part: takes frame bytes, tracks the offset and accumulates both sums.
module eiuc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  eiuc_pkg::t_in_item i_in,
    output logic               o_q_push,
    output eiuc_pkg::t_frame_sum o_q_data
);
    import eiuc_pkg::*;

    logic [OFFSET_BITS-1:0] r_offset, n_offset;
    logic [15:0]            r_ip_sum, n_ip_sum;
    logic [15:0]            r_udp_sum, n_udp_sum;
    logic [3:0]             r_hdr_words, n_hdr_words;
    t_frame_cfg             r_cfg, n_cfg;

    logic                first;
    logic                active;
    t_frame_cfg          cfg_eff;
    logic [3:0]          hw_eff;
    logic [CMP_BITS-1:0] o_x;
    logic [CMP_BITS-1:0] ip_end;
    logic [CMP_BITS-1:0] udp_end;
    logic [15:0]         v;
    logic                ip_hit;
    logic                udp_hit;

    always_comb begin
        first  = (r_offset == '0);
        active = (r_offset != {OFFSET_BITS{1'b1}});
        cfg_eff.mode     = i_in.check_mode;
        cfg_eff.exp_csum = i_in.expected_csum;
        cfg_eff.exp_ip   = i_in.expected_ip_csum;
        cfg_eff.comb     = i_in.combined_given;
        cfg_eff.len_ok   = i_in.length_given;
        cfg_eff.plen     = i_in.payload_length;
        if (!first) begin
            cfg_eff = r_cfg;
        end
        o_x     = CMP_BITS'(r_offset);
        hw_eff  = (o_x == CMP_BITS'(IP_START)) ? i_in.data_byte[3:0] : r_hdr_words;
        ip_end  = CMP_BITS'(IP_START) + CMP_BITS'({hw_eff, 2'b00});
        udp_end = CMP_BITS'(UDP_START + UDP_HDR_LEN) + CMP_BITS'(cfg_eff.plen);
        v       = r_offset[0] ? {8'd0, i_in.data_byte} : {i_in.data_byte, 8'd0};
        ip_hit  = (o_x >= CMP_BITS'(IP_START)) && (o_x < ip_end)
                  && (o_x != CMP_BITS'(IP_CSUM_HI)) && (o_x != CMP_BITS'(IP_CSUM_LO));
        udp_hit = (o_x >= CMP_BITS'(PSEUDO_START)) && (o_x < udp_end)
                  && (o_x != CMP_BITS'(UDP_CSUM_HI)) && (o_x != CMP_BITS'(UDP_CSUM_LO));
    end

    always_comb begin
        n_offset    = r_offset;
        n_ip_sum    = r_ip_sum;
        n_udp_sum   = r_udp_sum;
        n_hdr_words = r_hdr_words;
        n_cfg       = r_cfg;
        o_q_push    = 1'b0;
        o_q_data    = '0;
        if (i_accept) begin
            n_cfg = cfg_eff;
            if (active) begin
                n_hdr_words = hw_eff;
                if (ip_hit) begin
                    n_ip_sum = oc_add(r_ip_sum, v);
                end
                if (udp_hit) begin
                    n_udp_sum = oc_add(r_udp_sum, v);
                end
                n_offset = r_offset + 1'b1;
            end
            if (i_in.last_byte) begin
                o_q_push           = 1'b1;
                o_q_data.n_bytes   = n_offset;
                o_q_data.ip_sum    = n_ip_sum;
                o_q_data.udp_sum   = n_udp_sum;
                o_q_data.hdr_words = n_hdr_words;
                o_q_data.cfg       = cfg_eff;
                n_offset    = '0;
                n_ip_sum    = '0;
                n_udp_sum   = '0;
                n_hdr_words = '0;
                n_cfg       = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_ip_sum    <= '0;
            r_udp_sum   <= '0;
            r_hdr_words <= '0;
            r_cfg       <= '0;
        end else begin
            r_offset    <= n_offset;
            r_ip_sum    <= n_ip_sum;
            r_udp_sum   <= n_udp_sum;
            r_hdr_words <= n_hdr_words;
            r_cfg       <= n_cfg;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in.last_byte) |=> (r_offset == '0 && r_ip_sum == '0 && r_udp_sum == '0))
        else $error("frame state not cleared after the last byte");

endmodule

@@ hw/rtl/eiuc_queue.sv @@
// Short queue of frame summaries between the front and back parts.
module eiuc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  eiuc_pkg::t_frame_sum i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output eiuc_pkg::t_frame_sum o_data
);
    import eiuc_pkg::*;

    t_frame_sum        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_push_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && o_full && !i_pop) |=> (r_count == QCNT_W'(QDEPTH)))
        else $error("queue count changed on a refused push");

endmodule

@@ hw/rtl/eiuc_back.sv @@
// Back part: finishes the checksums of one frame and holds the result register.
module eiuc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  eiuc_pkg::t_frame_sum i_q_data,
    output logic                 o_q_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output eiuc_pkg::t_out_item  o_out
);
    import eiuc_pkg::*;

    logic      r_valid;
    t_out_item r_out, n_out;

    logic                both;
    logic                ip_cov;
    logic                udp_cov;
    logic [CMP_BITS-1:0] n_x;
    logic                ip_short;
    logic                udp_short;
    logic                short_f;
    logic [15:0]         udp_len;
    logic [15:0]         s1;
    logic [15:0]         s2;
    logic [15:0]         ip_c;
    logic [15:0]         udp_c;
    logic                pass;

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_out   = r_out;

    always_comb begin
        both    = i_q_data.cfg.comb && i_q_data.cfg.len_ok;
        ip_cov  = (i_q_data.cfg.mode == MODE_IP) || (i_q_data.cfg.mode == MODE_BOTH && both);
        udp_cov = (i_q_data.cfg.mode == MODE_UDP && i_q_data.cfg.len_ok)
                  || (i_q_data.cfg.mode == MODE_BOTH && both);
        n_x       = CMP_BITS'(i_q_data.n_bytes);
        ip_short  = ip_cov && ((n_x <= CMP_BITS'(IP_START))
                    || (n_x < CMP_BITS'(IP_START) + CMP_BITS'({i_q_data.hdr_words, 2'b00})));
        udp_short = udp_cov
                    && (n_x < CMP_BITS'(UDP_START + UDP_HDR_LEN) + CMP_BITS'(i_q_data.cfg.plen));
        short_f   = ip_short || udp_short;
        udp_len   = i_q_data.cfg.plen + 16'(UDP_HDR_LEN);
        s1        = oc_add(i_q_data.udp_sum, 16'(UDP_PROTO));
        s2        = oc_add(s1, udp_len);
        ip_c      = (!short_f && ip_cov) ? ~i_q_data.ip_sum : 16'd0;
        udp_c     = (!short_f && udp_cov) ? ~s2 : 16'd0;
        pass      = 1'b0;
        if (!short_f) begin
            case (i_q_data.cfg.mode)
                MODE_IP: begin
                    pass = (ip_c == i_q_data.cfg.exp_csum);
                end
                MODE_UDP: begin
                    pass = udp_cov && (udp_c == i_q_data.cfg.exp_csum);
                end
                MODE_BOTH: begin
                    pass = both && (udp_c == i_q_data.cfg.exp_csum)
                           && (ip_c == i_q_data.cfg.exp_ip);
                end
                default: begin
                    pass = 1'b0;
                end
            endcase
        end
        n_out.checks_pass       = pass;
        n_out.computed_udp_csum = udp_c;
        n_out.computed_ip_csum  = ip_c;
        n_out.frame_too_short   = short_f;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    a_short_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.frame_too_short) |->
        (!r_out.checks_pass && r_out.computed_ip_csum == '0 && r_out.computed_udp_csum == '0))
        else $error("short frame result carries checksums or a pass");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_out)))
        else $error("waiting result changed before its transfer");

endmodule
